// ===== rtl/core/fuzzy_pid_gain_scheduler_defines.svh =====
// Assertion macros shared by the fuzzy PID gain scheduler RTL.
`ifndef FUZZY_PID_GAIN_SCHEDULER_DEFINES_SVH
`define FUZZY_PID_GAIN_SCHEDULER_DEFINES_SVH

// Same-cycle implication, disabled while reset is asserted.
`define FPGS_ASSERT_IMP(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, disabled while reset is asserted.
`define FPGS_ASSERT_NXT(lbl, clk_s, rst_s, ante, cons, msg) \
	lbl: assert property (@(posedge clk_s) disable iff (!rst_s) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== rtl/core/fpgs_pkg.sv =====
// ----------------------------------------------------------------------------
// fpgs_pkg
// Types, codes and helper functions for the fuzzy PID gain scheduler.
// ----------------------------------------------------------------------------
`default_nettype none

package fpgs_pkg;

	localparam int LEVELS     = 7;
	localparam int TABLE_SIZE = LEVELS * LEVELS;
	localparam int STORE_SIZE = 3 * TABLE_SIZE;
	localparam int ADDR_W     = 8;
	localparam int MUL_B_W    = 17;

	localparam logic OP_LOAD   = 1'b0;
	localparam logic OP_SAMPLE = 1'b1;

	localparam logic [2:0] REG_MAX_SPEED   = 3'd0;
	localparam logic [2:0] REG_ERROR_SCALE = 3'd1;
	localparam logic [2:0] REG_RATE_SCALE  = 3'd2;
	localparam logic [2:0] REG_KP_SCALE    = 3'd3;
	localparam logic [2:0] REG_KI_SCALE    = 3'd4;
	localparam logic [2:0] REG_KD_SCALE    = 3'd5;

	localparam logic [1:0] TBL_KP = 2'd0;
	localparam logic [1:0] TBL_KI = 2'd1;
	localparam logic [1:0] TBL_KD = 2'd2;

	typedef enum logic [3:0] {
		ST_IDLE,
		ST_ERR,
		ST_PE,
		ST_PC,
		ST_GAP,
		ST_WGT,
		ST_RD,
		ST_TERM,
		ST_ACC,
		ST_LO,
		ST_HI,
		ST_FIN,
		ST_OUT
	} state_t;

	typedef enum logic [2:0] {
		D_NONE,
		D_PE,
		D_PC,
		D_WGT,
		D_TERM,
		D_LO,
		D_HI
	} dest_t;

	typedef struct packed {
		logic signed [3:0] lvl;
		logic [8:0]        wl;
		logic [8:0]        wr;
	} fuzz_t;

	function automatic logic [ADDR_W-1:0] rule_addr(input logic [1:0] t,
		input logic [2:0] row, input logic [2:0] col);
		rule_addr = ADDR_W'(t) * ADDR_W'(TABLE_SIZE) + ADDR_W'(row) * ADDR_W'(LEVELS)
			+ ADDR_W'(col);
	endfunction

	// Left level and the two linear weights for a Q8.8 position.
	function automatic fuzz_t fuzzify(input logic signed [11:0] p);
		fuzz_t             f;
		logic signed [11:0] np;
		logic signed [3:0]  l;
		logic signed [12:0] t;
		np = -p;
		if (p > 12'sd768) begin
			l = 4'sd3;
		end else if (p < -12'sd768) begin
			l = -4'sd4;
		end else if (p > 12'sd0) begin
			l = $signed({1'b0, p[10:8]});
		end else begin
			l = -$signed({1'b0, np[10:8]}) - 4'sd1;
		end
		f.lvl = l;
		if (l == -4'sd4) begin
			f.wl = 9'd0;
		end else if (l == 4'sd3) begin
			f.wl = 9'd256;
		end else begin
			t = 13'($signed({l + 4'sd1, 8'h00})) - 13'(p);
			f.wl = t[8:0];
		end
		if (l == 4'sd3) begin
			f.wr = 9'd0;
		end else if (l == -4'sd4) begin
			f.wr = 9'd256;
		end else begin
			t = 13'(p) - 13'($signed({l, 8'h00}));
			f.wr = t[8:0];
		end
		return f;
	endfunction

endpackage

`default_nettype wire

// ===== rtl/core/fpgs_mul.sv =====
// ----------------------------------------------------------------------------
// fpgs_mul
// Shared signed multiplier with a registered product.
// ----------------------------------------------------------------------------
`default_nettype none

module fpgs_mul import fpgs_pkg::*; #(
	parameter int A_W = 18
) (
	input  wire                              clk,
	input  wire logic signed [A_W-1:0]       a,
	input  wire logic signed [MUL_B_W-1:0]   b,
	output logic signed [A_W+MUL_B_W-1:0]    p
);

	always_ff @(posedge clk) begin
		p <= (A_W+MUL_B_W)'(a) * (A_W+MUL_B_W)'(b);
	end

endmodule

`default_nettype wire

// ===== rtl/core/fpgs_rule_mem.sv =====
// ----------------------------------------------------------------------------
// fpgs_rule_mem
// Rule store for the three 7x7 tables, one write and one registered read.
// ----------------------------------------------------------------------------
`default_nettype none

module fpgs_rule_mem import fpgs_pkg::*; #(
	parameter int RULE_WIDTH = 8
) (
	input  wire                    clk,
	input  wire                    we,
	input  wire [ADDR_W-1:0]       waddr,
	input  wire [RULE_WIDTH-1:0]   wdata,
	input  wire [ADDR_W-1:0]       raddr,
	output logic [RULE_WIDTH-1:0]  rdata
);

	logic [RULE_WIDTH-1:0] rule_mem [STORE_SIZE];

	always_ff @(posedge clk) begin
		if (we) begin
			rule_mem[waddr] <= wdata;
		end
	end

	always_ff @(posedge clk) begin
		rdata <= rule_mem[raddr];
	end

endmodule

`default_nettype wire

// ===== rtl/core/fuzzy_pid_gain_scheduler.sv =====
// Rule load: one transfer per cycle, accepted back to back while idle.
// Speed sample: no new transfer is accepted until the result is registered;
// the single shared multiplier is issued 24 times per sample.
// A pending result holds the sequencer in its last state until taken.
// Reset (arst_n low, asynchronous) clears control, history and registers to
// defaults; the rule store is not cleared and must be loaded before use.
// ----------------------------------------------------------------------------
// fuzzy_pid_gain_scheduler
// Fuzzy self-tuning PID gain scheduler with 7x7 rule tables and bilinear blend.
// ----------------------------------------------------------------------------
`default_nettype none
`include "fuzzy_pid_gain_scheduler_defines.svh"

module fuzzy_pid_gain_scheduler import fpgs_pkg::*; #(
	parameter int SPEED_WIDTH = 16,
	parameter int RULE_WIDTH  = 8
) (
	input  wire        clk,
	input  wire        arst_n,
	input  wire        cfg_we,
	input  wire [2:0]  cfg_index,
	input  wire [15:0] cfg_data,
	input  wire        s_tvalid,
	output logic       s_tready,
	// table_select, rule_row, rule_col, rule_value, target_speed, current_speed
	input  wire [((8+RULE_WIDTH+2*SPEED_WIDTH+7)/8)*8-1:0] s_tdata,
	// op
	input  wire        s_tuser,
	output logic       m_tvalid,
	input  wire        m_tready,
	// delta_kp, delta_ki, delta_kd, error, error_change, error_sum
	output logic [((128+2*SPEED_WIDTH+3+7)/8)*8-1:0] m_tdata
);

	localparam int SW    = SPEED_WIDTH;
	localparam int RW    = RULE_WIDTH;
	localparam int EW    = SW + 1;
	localparam int DW    = SW + 2;
	localparam int CW    = ((SW > 16) ? SW : 16) + 1;
	localparam int SUMW  = ((EW > 32) ? EW : 32) + 1;
	localparam int MAW   = (SW + 2 > 18) ? SW + 2 : 18;
	localparam int PW    = MAW + MUL_B_W;
	localparam int ACCW  = RW + 17;
	localparam int OUT_W = ((128 + 2*SW + 3 + 7) / 8) * 8;
	localparam int V_LO  = 8;
	localparam int T_LO  = 8 + RW;
	localparam int C_LO  = 8 + RW + SW;
	localparam logic signed [PW-1:0] P_HI = PW'(769);
	localparam logic signed [PW-1:0] P_LO = -PW'(769);
	localparam logic signed [SUMW-1:0] S_MAX = SUMW'(33'sh0_7FFF_FFFF);
	localparam logic signed [SUMW-1:0] S_MIN = SUMW'(-33'sh0_8000_0000);

	state_t state_q, state_d;
	dest_t  dest_q, dest_d;

	logic [14:0] max_speed_q;
	logic [15:0] error_scale_q, rate_scale_q, kp_scale_q, ki_scale_q, kd_scale_q;

	logic signed [SW-1:0] tgt_q, cur_q;
	logic signed [EW-1:0] prev_q, err_q;
	logic signed [DW-1:0] dec_q;
	logic signed [31:0]   total_q, sum_q;

	logic [1:0] k_q, t_q, dk_q;
	logic signed [3:0] el_q, cl_q;
	logic [8:0] ewl_q, ewr_q, cwl_q, cwr_q;
	logic [16:0] w_q [4];
	logic signed [ACCW-1:0] acc_q;
	logic [15:0] lo_q;
	logic [31:0] delta_q [3];

	logic signed [MAW-1:0]     mul_a;
	logic signed [MUL_B_W-1:0] mul_b;
	logic signed [PW-1:0]      prod_q;

	logic [ADDR_W-1:0] raddr;
	logic [RW-1:0]     rdata;
	logic              wr_en;
	logic              accept;

	// error stage
	logic signed [CW-1:0]   tgt_x, ms_x, tgt_c;
	logic signed [EW-1:0]   err_c;
	logic signed [DW-1:0]   dec_c;
	logic signed [SUMW-1:0] sum_w;
	logic signed [31:0]     sum_c;

	// fuzzify
	logic signed [PW-1:0] pe_full;
	logic signed [11:0]   p12;
	fuzz_t                fz;

	// neighbour address
	logic [1:0]        kk;
	logic signed [3:0] e3, c3;
	logic [15:0]       scale_sel;

	assign accept = s_tvalid && s_tready;
	assign wr_en  = accept && (s_tuser == OP_LOAD) && (s_tdata[1:0] != 2'd3)
		&& (s_tdata[4:2] != 3'd7) && (s_tdata[7:5] != 3'd7);

	fpgs_mul #(.A_W(MAW)) u_mul (
		.clk (clk),
		.a   (mul_a),
		.b   (mul_b),
		.p   (prod_q)
	);

	fpgs_rule_mem #(.RULE_WIDTH(RW)) u_mem (
		.clk   (clk),
		.we    (wr_en),
		.waddr (rule_addr(s_tdata[1:0], s_tdata[4:2], s_tdata[7:5])),
		.wdata (s_tdata[V_LO+RW-1:V_LO]),
		.raddr (raddr),
		.rdata (rdata)
	);

	// configuration
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			max_speed_q   <= 15'd32767;
			error_scale_q <= 16'd256;
			rate_scale_q  <= 16'd256;
			kp_scale_q    <= 16'd256;
			ki_scale_q    <= 16'd256;
			kd_scale_q    <= 16'd256;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_MAX_SPEED:   max_speed_q   <= cfg_data[14:0];
				REG_ERROR_SCALE: error_scale_q <= cfg_data;
				REG_RATE_SCALE:  rate_scale_q  <= cfg_data;
				REG_KP_SCALE:    kp_scale_q    <= cfg_data;
				REG_KI_SCALE:    ki_scale_q    <= cfg_data;
				REG_KD_SCALE:    kd_scale_q    <= cfg_data;
				default: ;
			endcase
		end
	end

	// clamp, error, change and saturating sum
	always_comb begin
		tgt_x = CW'(tgt_q);
		ms_x  = $signed(CW'(max_speed_q));
		if (tgt_x > ms_x) begin
			tgt_c = ms_x;
		end else if (tgt_x < -ms_x) begin
			tgt_c = -ms_x;
		end else begin
			tgt_c = tgt_x;
		end
		err_c = EW'(tgt_c) - EW'(cur_q);
		dec_c = DW'(err_c) - DW'(prev_q);
		sum_w = SUMW'(total_q) + SUMW'(err_c);
		if (sum_w > S_MAX) begin
			sum_c = 32'sh7FFF_FFFF;
		end else if (sum_w < S_MIN) begin
			sum_c = -32'sh8000_0000;
		end else begin
			sum_c = sum_w[31:0];
		end
	end

	// saturate the Q8.8 position; beyond +/-768 only the side matters
	always_comb begin
		pe_full = prod_q >>> 8;
		if (pe_full > P_HI) begin
			p12 = 12'sd769;
		end else if (pe_full < P_LO) begin
			p12 = -12'sd769;
		end else begin
			p12 = $signed(pe_full[11:0]);
		end
		fz = fuzzify(p12);
	end

	always_comb begin
		unique case (t_q)
			TBL_KP:  scale_sel = kp_scale_q;
			TBL_KI:  scale_sel = ki_scale_q;
			default: scale_sel = kd_scale_q;
		endcase
	end

	// read address of the neighbour fetched for the next term
	always_comb begin
		kk = (state_q == ST_RD) ? 2'd0 : k_q + 2'd1;
		e3 = el_q + 4'sd3 + $signed({3'b000, kk[0]});
		c3 = cl_q + 4'sd3 + $signed({3'b000, kk[1]});
		if (e3 >= 4'sd0 && e3 <= 4'sd6 && c3 >= 4'sd0 && c3 <= 4'sd6) begin
			raddr = rule_addr(t_q, c3[2:0], e3[2:0]);
		end else begin
			raddr = '0;
		end
	end

	// next state
	always_comb begin
		state_d = state_q;
		unique case (state_q)
			ST_IDLE: if (s_tvalid && s_tuser == OP_SAMPLE) state_d = ST_ERR;
			ST_ERR:  state_d = ST_PE;
			ST_PE:   state_d = ST_PC;
			ST_PC:   state_d = ST_GAP;
			ST_GAP:  state_d = ST_WGT;
			ST_WGT:  if (k_q == 2'd3) state_d = ST_RD;
			ST_RD:   state_d = ST_TERM;
			ST_TERM: if (k_q == 2'd3) state_d = ST_ACC;
			ST_ACC:  state_d = ST_LO;
			ST_LO:   state_d = ST_HI;
			ST_HI:   state_d = (t_q == TBL_KD) ? ST_FIN : ST_RD;
			ST_FIN:  state_d = ST_OUT;
			ST_OUT:  if (!m_tvalid || m_tready) state_d = ST_IDLE;
			default: state_d = ST_IDLE;
		endcase
	end

	// multiplier issue and handshake outputs
	always_comb begin
		s_tready = (state_q == ST_IDLE);
		mul_a    = '0;
		mul_b    = '0;
		dest_d   = D_NONE;
		unique case (state_q)
			ST_PE: begin
				mul_a  = MAW'(err_q);
				mul_b  = $signed(MUL_B_W'(error_scale_q));
				dest_d = D_PE;
			end
			ST_PC: begin
				mul_a  = MAW'(dec_q);
				mul_b  = $signed(MUL_B_W'(rate_scale_q));
				dest_d = D_PC;
			end
			ST_WGT: begin
				mul_a  = $signed(MAW'(k_q[0] ? ewr_q : ewl_q));
				mul_b  = $signed(MUL_B_W'(k_q[1] ? cwr_q : cwl_q));
				dest_d = D_WGT;
			end
			ST_TERM: begin
				mul_a  = $signed(MAW'(w_q[k_q]));
				mul_b  = (w_q[k_q] == 17'd0) ? '0 : MUL_B_W'($signed(rdata));
				dest_d = D_TERM;
			end
			ST_LO: begin
				mul_a  = $signed(MAW'(acc_q[15:0]));
				mul_b  = $signed(MUL_B_W'(scale_sel));
				dest_d = D_LO;
			end
			ST_HI: begin
				mul_a  = MAW'($signed(acc_q[ACCW-1:16]));
				mul_b  = $signed(MUL_B_W'(scale_sel));
				dest_d = D_HI;
			end
			default: ;
		endcase
	end

	// sequencer control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			dest_q  <= D_NONE;
			k_q     <= 2'd0;
			t_q     <= 2'd0;
			dk_q    <= 2'd0;
			prev_q  <= '0;
			total_q <= '0;
		end else begin
			state_q <= state_d;
			dest_q  <= dest_d;
			dk_q    <= (state_q == ST_HI) ? t_q : k_q;
			if (state_q == ST_ERR) begin
				prev_q  <= err_c;
				total_q <= sum_c;
				t_q     <= TBL_KP;
			end
			if (state_q == ST_WGT || state_q == ST_TERM) begin
				k_q <= k_q + 2'd1;
			end
			if (state_q == ST_HI) begin
				t_q <= t_q + 2'd1;
			end
		end
	end

	// datapath registers: capture sample and consume the product
	always_ff @(posedge clk) begin
		if (accept) begin
			tgt_q <= $signed(s_tdata[T_LO+SW-1:T_LO]);
			cur_q <= $signed(s_tdata[C_LO+SW-1:C_LO]);
		end
		if (state_q == ST_ERR) begin
			err_q <= err_c;
			dec_q <= dec_c;
			sum_q <= sum_c;
		end
		if (state_q == ST_RD) begin
			acc_q <= '0;
		end
		unique case (dest_q)
			D_PE: begin
				el_q  <= fz.lvl;
				ewl_q <= fz.wl;
				ewr_q <= fz.wr;
			end
			D_PC: begin
				cl_q  <= fz.lvl;
				cwl_q <= fz.wl;
				cwr_q <= fz.wr;
			end
			D_WGT:  w_q[dk_q] <= prod_q[16:0];
			D_TERM: acc_q <= acc_q + prod_q[ACCW-1:0];
			D_LO:   lo_q <= prod_q[31:16];
			D_HI:   delta_q[dk_q] <= prod_q[31:0] + {16'h0000, lo_q};
			default: ;
		endcase
	end

	// output register: hold until the transfer completes
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m_tvalid <= 1'b0;
		end else if (state_q == ST_OUT && (!m_tvalid || m_tready)) begin
			m_tvalid <= 1'b1;
		end else if (m_tready) begin
			m_tvalid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (state_q == ST_OUT && (!m_tvalid || m_tready)) begin
			m_tdata <= OUT_W'({sum_q, dec_q, err_q, delta_q[2], delta_q[1], delta_q[0]});
		end
	end

	`FPGS_ASSERT_NXT(a_sample_starts, clk, arst_n, accept && s_tuser == OP_SAMPLE, state_q == ST_ERR, "sample transfer did not start the sequencer")
	`FPGS_ASSERT_NXT(a_load_stays_idle, clk, arst_n, accept && s_tuser == OP_LOAD, s_tready, "rule load left the block busy")
	`FPGS_ASSERT_IMP(a_weights_sum, clk, arst_n, state_q == ST_WGT, (10'(ewl_q) + 10'(ewr_q) == 10'd256) && (10'(cwl_q) + 10'(cwr_q) == 10'd256), "membership weights do not sum to one")

endmodule

`default_nettype wire

// ===== tb/tb_fuzzy_pid_gain_scheduler.sv =====
// ----------------------------------------------------------------------------
// tb_fuzzy_pid_gain_scheduler
// Loads the three rule tables, then sends speed samples under several register
// settings. Every result is checked field by field against a local prediction
// of the error terms and blended gain deltas.
// ----------------------------------------------------------------------------
`default_nettype none

module tb_fuzzy_pid_gain_scheduler import fpgs_pkg::*; ();

	timeunit 1ns;
	timeprecision 1ps;

	localparam int SW = 16;
	localparam int RW = 8;
	localparam int IN_W = 48;
	localparam int OUT_W = 168;
	localparam int SETTLE = 40;

	typedef struct {
		logic [31:0] kp;
		logic [31:0] ki;
		logic [31:0] kd;
		logic [16:0] err;
		logic [17:0] dec;
		logic [31:0] sum;
	} gains_t;

	logic clk = 1'b0;
	logic arst_n = 1'b0;
	logic cfg_we = 1'b0;
	logic [2:0] cfg_index = '0;
	logic [15:0] cfg_data = '0;
	logic s_tvalid = 1'b0;
	logic s_tready;
	// table_select, rule_row, rule_col, rule_value, target_speed, current_speed
	logic [IN_W-1:0] s_tdata = '0;
	// op
	logic s_tuser = 1'b0;
	logic m_tvalid;
	logic m_tready = 1'b0;
	// delta_kp, delta_ki, delta_kd, error, error_change, error_sum
	logic [OUT_W-1:0] m_tdata;

	fuzzy_pid_gain_scheduler #(.SPEED_WIDTH(SW), .RULE_WIDTH(RW)) u_dut (
		.clk(clk), .arst_n(arst_n),
		.cfg_we(cfg_we), .cfg_index(cfg_index), .cfg_data(cfg_data),
		.s_tvalid(s_tvalid), .s_tready(s_tready), .s_tdata(s_tdata), .s_tuser(s_tuser),
		.m_tvalid(m_tvalid), .m_tready(m_tready), .m_tdata(m_tdata)
	);

	// scheduler copy
	longint unsigned max_speed, err_scale, rate_scale;
	longint unsigned gain_scale [3];
	longint prev_err, err_total;
	logic signed [RW-1:0] rules [STORE_SIZE];

	gains_t pending_gains [$];
	int errors = 0;
	int samples_sent = 0, loads_sent = 0, results_seen = 0, cfg_writes = 0;
	int burst_left = 0;

	initial forever #6 clk = ~clk;

	initial begin
		#50ms;
		$display("tb_fuzzy_pid_gain_scheduler NOT OK");
		$finish;
	end

	// Left level and weights of a Q8.8 position
	function automatic void level_weights(input longint p, output int l,
		output longint wl, output longint wr);
		if (p > 768) l = 3;
		else if (p < -768) l = -4;
		else if (p > 0) l = int'(p >>> 8);
		else l = -int'((-p) >>> 8) - 1;
		if (l < -3) wl = 0;
		else if (l == 3) wl = 256;
		else wl = longint'(l + 1) * 256 - p;
		if (l + 1 > 3) wr = 0;
		else if (l + 1 == -3) wr = 256;
		else wr = p - longint'(l) * 256;
	endfunction

	function automatic longint rule_entry(int t, int ec, int e);
		if (ec < -3 || ec > 3 || e < -3 || e > 3) return 0;
		return longint'(rules[t * TABLE_SIZE + (ec + 3) * LEVELS + (e + 3)]);
	endfunction

	function automatic longint blend_gain(int t, int el, longint ewl, longint ewr,
		int cl, longint cwl, longint cwr);
		longint acc;
		acc = 0;
		if (ewl != 0 && cwl != 0) acc += ewl * cwl * rule_entry(t, cl, el);
		if (ewl != 0 && cwr != 0) acc += ewl * cwr * rule_entry(t, cl + 1, el);
		if (ewr != 0 && cwl != 0) acc += ewr * cwl * rule_entry(t, cl, el + 1);
		if (ewr != 0 && cwr != 0) acc += ewr * cwr * rule_entry(t, cl + 1, el + 1);
		return (acc * longint'(gain_scale[t])) >>> 16;
	endfunction

	function automatic gains_t schedule_gains(logic signed [SW-1:0] tgt_in,
		logic signed [SW-1:0] cur_in);
		gains_t g;
		longint tgt, err, dec, sum, pe, pc, ewl, ewr, cwl, cwr;
		int el, cl;
		tgt = tgt_in;
		if (tgt > longint'(max_speed)) tgt = max_speed;
		else if (tgt < -longint'(max_speed)) tgt = -longint'(max_speed);
		err = tgt - longint'(cur_in);
		dec = err - prev_err;
		sum = err_total + err;
		if (sum > 64'sd2147483647) sum = 64'sd2147483647;
		else if (sum < -64'sd2147483648) sum = -64'sd2147483648;
		err_total = sum;
		prev_err = err;
		pe = (err * longint'(err_scale)) >>> 8;
		pc = (dec * longint'(rate_scale)) >>> 8;
		level_weights(pe, el, ewl, ewr);
		level_weights(pc, cl, cwl, cwr);
		g.kp = 32'(blend_gain(TBL_KP, el, ewl, ewr, cl, cwl, cwr));
		g.ki = 32'(blend_gain(TBL_KI, el, ewl, ewr, cl, cwl, cwr));
		g.kd = 32'(blend_gain(TBL_KD, el, ewl, ewr, cl, cwl, cwr));
		g.err = 17'(err);
		g.dec = 18'(dec);
		g.sum = 32'(sum);
		return g;
	endfunction

	task automatic send_item(logic op, logic [IN_W-1:0] data);
		s_tuser = op;
		s_tdata = data;
		s_tvalid = 1'b1;
		do @(posedge clk); while (!s_tready);
		if (op == OP_SAMPLE) begin
			pending_gains.push_back(schedule_gains(data[31:16], data[47:32]));
			samples_sent++;
		end else begin
			if (data[1:0] != 2'd3 && data[4:2] != 3'd7 && data[7:5] != 3'd7)
				rules[rule_addr(data[1:0], data[4:2], data[7:5])] = data[15:8];
			loads_sent++;
		end
		@(negedge clk);
		if (burst_left > 0) begin
			burst_left--;
		end else begin
			s_tvalid = 1'b0;
			repeat ($urandom_range(0, 3) == 0 ? 0 : $urandom_range(1, 12)) @(negedge clk);
			burst_left = $urandom_range(0, 3) == 0 ? $urandom_range(20, 60) : $urandom_range(0, 6);
		end
	endtask

	task automatic send_load(logic [1:0] t, logic [2:0] r, logic [2:0] c, logic [7:0] v);
		send_item(OP_LOAD, {32'($urandom()), v, c, r, t});
	endtask

	task automatic send_sample(logic [15:0] tgt, logic [15:0] cur);
		send_item(OP_SAMPLE, {cur, tgt, 8'($urandom()), 8'($urandom())});
	endtask

	task automatic wait_drained();
		s_tvalid = 1'b0;
		while (pending_gains.size() != 0) @(negedge clk);
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_reg(logic [2:0] idx, logic [15:0] val);
		cfg_we = 1'b1;
		cfg_index = idx;
		cfg_data = val;
		@(negedge clk);
		cfg_we = 1'b0;
		case (idx)
			REG_MAX_SPEED: max_speed = val[14:0];
			REG_ERROR_SCALE: err_scale = val;
			REG_RATE_SCALE: rate_scale = val;
			REG_KP_SCALE: gain_scale[0] = val;
			REG_KI_SCALE: gain_scale[1] = val;
			REG_KD_SCALE: gain_scale[2] = val;
			default: ;
		endcase
		cfg_writes++;
	endtask

	task automatic write_all(logic [15:0] ms, logic [15:0] es, logic [15:0] rs,
		logic [15:0] kp, logic [15:0] ki, logic [15:0] kd);
		wait_drained();
		write_reg(REG_MAX_SPEED, ms);
		write_reg(REG_ERROR_SCALE, es);
		write_reg(REG_RATE_SCALE, rs);
		write_reg(REG_KP_SCALE, kp);
		write_reg(REG_KI_SCALE, ki);
		write_reg(REG_KD_SCALE, kd);
	endtask

	// Every entry is written here before any sample can read it
	task automatic test_load_tables();
		for (int t = 0; t < 3; t++)
			for (int r = 0; r < LEVELS; r++)
				for (int c = 0; c < LEVELS; c++)
					send_load(2'(t), 3'(r), 3'(c), 8'($urandom()));
		// out-of-range loads are dropped, then two in-range entries are rewritten
		send_load(2'd3, 3'd1, 3'd1, 8'h55);
		send_load(TBL_KI, 3'd7, 3'd0, 8'h80);
		send_load(TBL_KD, 3'd0, 3'd7, 8'h7f);
		send_load(TBL_KP, 3'd3, 3'd3, 8'h80);
		send_load(TBL_KD, 3'd6, 3'd6, 8'h7f);
	endtask

	task automatic test_directed_samples();
		send_sample(16'sd0, 16'sd0);
		send_sample(16'sd32767, -16'sd32768);
		send_sample(-16'sd32768, 16'sd32767);
		send_sample(-16'sd32768, -16'sd32768);
		send_sample(16'sd768, 16'sd0);
		send_sample(16'sd769, 16'sd0);
		send_sample(-16'sd768, 16'sd0);
		send_sample(-16'sd769, 16'sd0);
		send_sample(16'sd256, 16'sd0);
		send_sample(16'sd0, 16'sd256);
		send_sample(16'sd1, 16'sd0);
		send_sample(16'sd0, 16'sd1);
		send_sample(16'hffff, 16'h0000);
		write_all(16'd0, 16'd256, 16'd256, 16'd256, 16'd256, 16'd256);
		send_sample(16'sd32767, 16'sd5);
		send_sample(-16'sd32768, -16'sd5);
		write_all(16'd100, 16'd65535, 16'd65535, 16'd65535, 16'd65535, 16'd65535);
		send_sample(16'sd300, -16'sd20);
		send_sample(-16'sd300, 16'sd20);
		send_sample(16'sd1, 16'sd0);
		write_all(16'h7fff, 16'd0, 16'd0, 16'd0, 16'd0, 16'd0);
		send_sample(16'sd200, 16'sd3);
	endtask

	function automatic logic [15:0] pick_speed(int spread);
		case ($urandom_range(0, 5))
			0: return 16'($urandom());
			1: return $urandom_range(0, 1) ? 16'sd32767 : -16'sd32768;
			default: return 16'($signed(int'($urandom_range(0, 2 * spread)) - spread));
		endcase
	endfunction

	task automatic test_random_phases();
		int spread;
		for (int ph = 0; ph < 9; ph++) begin
			case (ph)
				0: write_all(16'h7fff, 16'd256, 16'd256, 16'd256, 16'd256, 16'd256);
				1: write_all(16'hffff, 16'd16, 16'd8, 16'd65535, 16'd1, 16'd4096);
				2: write_all(16'd500, 16'd1024, 16'd2048, 16'd300, 16'd300, 16'd300);
				default: write_all(16'($urandom()), 16'($urandom_range(0, 3) == 0 ? $urandom() :
					$urandom_range(1, 1024)), 16'($urandom_range(0, 3) == 0 ? $urandom() :
					$urandom_range(1, 1024)), 16'($urandom()), 16'($urandom()),
					16'($urandom()));
			endcase
			// keep positions mostly inside the table so interior blends occur
			spread = (err_scale == 0) ? 1000 : int'(256 * 1100 / err_scale) + 4;
			for (int i = 0; i < 200; i++) begin
				if ($urandom_range(0, 9) == 0)
					send_load($urandom_range(0, 3) == 0 ? 2'($urandom()) : 2'($urandom_range(0, 2)),
						3'($urandom_range(0, 6)), 3'($urandom_range(0, 6)), 8'($urandom()));
				else
					send_sample(pick_speed(spread), pick_speed(spread));
				// hold off until the pipeline is empty
				if ($urandom_range(0, 60) == 0) wait_drained();
			end
		end
	endtask

	initial begin
		max_speed = 32767;
		err_scale = 256;
		rate_scale = 256;
		gain_scale = '{256, 256, 256};
		prev_err = 0;
		err_total = 0;
		repeat (2) @(posedge clk);
		@(negedge clk);
		arst_n = 1'b1;
		@(negedge clk);
		test_load_tables();
		test_directed_samples();
		test_random_phases();
		wait_drained();
		$display("Covered %0d samples, %0d rule loads, %0d register writes; %0d results checked",
			samples_sent, loads_sent, cfg_writes, results_seen);
		if (errors == 0 && pending_gains.size() == 0)
			$display("tb_fuzzy_pid_gain_scheduler OK");
		else
			$display("tb_fuzzy_pid_gain_scheduler NOT OK");
		$finish;
	end

	// Receiver stall pattern: phases of always-ready, fixed mask and random
	initial begin
		int mode, span;
		logic [7:0] mask;
		forever begin
			mode = $urandom_range(0, 2);
			mask = 8'($urandom());
			span = $urandom_range(50, 400);
			for (int i = 0; i < span; i++) begin
				@(negedge clk);
				case (mode)
					0: m_tready = 1'b1;
					1: m_tready = mask[i % 8] | (mask == 0);
					default: m_tready = $urandom_range(0, 2) != 0;
				endcase
			end
		end
	end

	always @(posedge clk) begin
		if (arst_n && m_tvalid && m_tready) begin
			gains_t g;
			results_seen++;
			if (pending_gains.size() == 0) begin
				errors++;
				$display("%t: unexpected result %h", $time, m_tdata);
			end else begin
				g = pending_gains.pop_front();
				if (m_tdata[31:0] !== g.kp || m_tdata[63:32] !== g.ki ||
					m_tdata[95:64] !== g.kd || m_tdata[112:96] !== g.err ||
					m_tdata[130:113] !== g.dec || m_tdata[162:131] !== g.sum) begin
					errors++;
					$display("%t: mismatch exp kp %h ki %h kd %h err %h dec %h sum %h, got %h",
						$time, g.kp, g.ki, g.kd, g.err, g.dec, g.sum, m_tdata);
				end
			end
		end
	end

endmodule

`default_nettype wire
